>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl of the relay controller
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ddrc_pkg.sv
// shared types, constants and the vote counter of the relay controller
// no dependencies
`timescale 1ns / 1ps

package ddrc_pkg;

   localparam int TIME_W       = 32;
   localparam int MS_W         = 16;
   localparam int SAMPLE_W     = 8;
   localparam int VOTE_SAMPLES = 8;
   localparam int VOTE_BITS    = (VOTE_SAMPLES < SAMPLE_W) ? VOTE_SAMPLES : SAMPLE_W;
   localparam int COUNT_W      = $clog2(VOTE_BITS + 1);
   localparam int VOTE_HALF    = VOTE_SAMPLES / 2;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_CONFIRM = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIM_CONFIRM  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTOR_LEVEL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_LEVEL   = 3'd4;

   localparam logic [MS_W-1:0] VOLT_CONFIRM_RST = 16'd500;
   localparam logic [MS_W-1:0] LIM_CONFIRM_RST  = 16'd50;
   localparam logic [MS_W-1:0] MIN_INTERVAL_RST = 16'd300;

   typedef struct packed {
      logic [MS_W-1:0] volt_confirm_ms;
      logic [MS_W-1:0] lim_confirm_ms;
      logic [MS_W-1:0] min_interval_ms;
      logic            motor_level;
      logic            load_level;
   } cfg_type;

   // majority vote over the low sample bits
   function automatic logic vote(input logic [SAMPLE_W-1:0] samples);
      logic [COUNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < VOTE_BITS; i++) begin
         n = n + COUNT_W'(samples[i]);
      end
      return (32'(n) > VOTE_HALF);
   endfunction

endpackage

>>> hw/rtl/debounced_dual_relay_controller.sv
// Relay controller with debounced voltage and limit inputs. Each request is
// registered on entry and its result leaves through an output register. One
// request per cycle is taken while req_stall is low; the result is computed from
// the entry register and written to the output register as the debounce and relay
// registers update. Configuration is expected only while idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module debounced_dual_relay_controller (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [31:0]                        req_now_ms,
   input  logic [7:0]                         req_detector_samples,
   input  logic                               req_limit_raw_open,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_voltage_present,
   output logic                               rsp_limit_open,
   output logic                               rsp_motor_relay_on,
   output logic                               rsp_load_relay_on,
   output logic                               rsp_motor_pin_level,
   output logic                               rsp_load_pin_level,
   output logic                               rsp_motor_switched,
   output logic                               rsp_load_switched,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ddrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ddrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   ddrc_pkg::cfg_type cfg;

   logic                              in_valid_ff;
   logic [ddrc_pkg::TIME_W-1:0]       now_ff;
   logic [ddrc_pkg::SAMPLE_W-1:0]     samples_ff;
   logic                              lim_raw_ff;
   logic                              rsp_valid_ff;
   logic [7:0]                        rsp_ff, rsp_in;

   logic advance, take;
   logic volt_raw, volt_acc, lim_acc;
   logic motor_on, load_on, motor_sw, load_sw;
   logic motor_sw_seen, motor_on_target, load_sw_seen, load_on_target, rsp_held;

   // the registered request moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign volt_raw = ddrc_pkg::vote(samples_ff);

   ddrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ddrc_debounce u_volt (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .raw           (volt_raw),
      .now_ms        (now_ff),
      .confirm_ms    (cfg.volt_confirm_ms),
      .accepted_next (volt_acc)
   );

   ddrc_debounce u_lim (
      .clock         (clock),
      .reset         (reset),
      .enable        (advance),
      .raw           (lim_raw_ff),
      .now_ms        (now_ff),
      .confirm_ms    (cfg.lim_confirm_ms),
      .accepted_next (lim_acc)
   );

   ddrc_relay u_motor (
      .clock           (clock),
      .reset           (reset),
      .enable          (advance),
      .target          (volt_acc & lim_acc),
      .now_ms          (now_ff),
      .min_interval_ms (cfg.min_interval_ms),
      .state_next      (motor_on),
      .switched        (motor_sw)
   );

   ddrc_relay u_load (
      .clock           (clock),
      .reset           (reset),
      .enable          (advance),
      .target          (volt_acc),
      .now_ms          (now_ff),
      .min_interval_ms (cfg.min_interval_ms),
      .state_next      (load_on),
      .switched        (load_sw)
   );

   assign rsp_in = {load_sw, motor_sw,
                    ~(load_on ^ cfg.load_level), ~(motor_on ^ cfg.motor_level),
                    load_on, motor_on, lim_acc, volt_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         now_ff     <= req_now_ms;
         samples_ff <= req_detector_samples;
         lim_raw_ff <= req_limit_raw_open;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_voltage_present = rsp_ff[0];
   assign rsp_limit_open      = rsp_ff[1];
   assign rsp_motor_relay_on  = rsp_ff[2];
   assign rsp_load_relay_on   = rsp_ff[3];
   assign rsp_motor_pin_level = rsp_ff[4];
   assign rsp_load_pin_level  = rsp_ff[5];
   assign rsp_motor_switched  = rsp_ff[6];
   assign rsp_load_switched   = rsp_ff[7];

   assign motor_sw_seen   = rsp_valid && rsp_motor_switched;
   assign motor_on_target = rsp_motor_relay_on == (rsp_voltage_present && rsp_limit_open);
   assign load_sw_seen    = rsp_valid && rsp_load_switched;
   assign load_on_target  = rsp_load_relay_on == rsp_voltage_present;
   assign rsp_held        = rsp_valid && rsp_stall;

   `ASSERT_IMPL(a_motor_sw, clock, reset, motor_sw_seen, motor_on_target, "motor relay off target")
   `ASSERT_IMPL(a_load_sw, clock, reset, load_sw_seen, load_on_target, "load relay off target")
   `ASSERT_NEXT(a_rsp_held, clock, reset, !advance && rsp_held, rsp_valid, "stalled result lost")
   `ASSERT_NEXT(a_rsp_gone, clock, reset, !advance && !rsp_held, !rsp_valid, "stray result")

endmodule

>>> hw/rtl/ddrc_csr.sv
// configuration registers of the relay controller
// depends on ddrc_pkg
`timescale 1ns / 1ps

module ddrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ddrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddrc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ddrc_pkg::cfg_type                   cfg
);

   ddrc_pkg::cfg_type cfg_ff;
   ddrc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ddrc_pkg::CSR_VOLT_CONFIRM: cfg_in.volt_confirm_ms = csr_wdata;
            ddrc_pkg::CSR_LIM_CONFIRM:  cfg_in.lim_confirm_ms  = csr_wdata;
            ddrc_pkg::CSR_MIN_INTERVAL: cfg_in.min_interval_ms = csr_wdata;
            ddrc_pkg::CSR_MOTOR_LEVEL:  cfg_in.motor_level     = csr_wdata[0];
            ddrc_pkg::CSR_LOAD_LEVEL:   cfg_in.load_level      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_confirm_ms <= ddrc_pkg::VOLT_CONFIRM_RST;
         cfg_ff.lim_confirm_ms  <= ddrc_pkg::LIM_CONFIRM_RST;
         cfg_ff.min_interval_ms <= ddrc_pkg::MIN_INTERVAL_RST;
         cfg_ff.motor_level     <= 1'b0;
         cfg_ff.load_level      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/ddrc_debounce.sv
// one debounce channel: pending value, its start time and the accepted value
// depends on ddrc_pkg
`timescale 1ns / 1ps

module ddrc_debounce (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           raw,
   input  logic [ddrc_pkg::TIME_W-1:0]    now_ms,
   input  logic [ddrc_pkg::MS_W-1:0]      confirm_ms,
   output logic                           accepted_next
);

   logic                          accepted_ff, accepted_in;
   logic                          pending_ff, pending_in;
   logic [ddrc_pkg::TIME_W-1:0]   since_ff, since_in;
   logic [ddrc_pkg::TIME_W-1:0]   elapsed;

   assign elapsed = now_ms - since_ff;

   always_comb begin
      accepted_in = accepted_ff;
      pending_in  = pending_ff;
      since_in    = since_ff;
      if (raw != pending_ff) begin
         pending_in = raw;
         since_in   = now_ms;
      end else if (raw != accepted_ff &&
                   elapsed >= {{(ddrc_pkg::TIME_W - ddrc_pkg::MS_W){1'b0}}, confirm_ms}) begin
         accepted_in = raw;
      end
   end

   assign accepted_next = accepted_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= 1'b0;
         pending_ff  <= 1'b0;
         since_ff    <= '0;
      end else if (enable) begin
         accepted_ff <= accepted_in;
         pending_ff  <= pending_in;
         since_ff    <= since_in;
      end
   end

endmodule

>>> hw/rtl/ddrc_relay.sv
// one relay with minimum time between switches
// depends on ddrc_pkg
`timescale 1ns / 1ps

module ddrc_relay (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           target,
   input  logic [ddrc_pkg::TIME_W-1:0]    now_ms,
   input  logic [ddrc_pkg::MS_W-1:0]      min_interval_ms,
   output logic                           state_next,
   output logic                           switched
);

   logic                          state_ff, state_in;
   logic [ddrc_pkg::TIME_W-1:0]   last_ff, last_in;
   logic [ddrc_pkg::TIME_W-1:0]   elapsed;

   assign elapsed = now_ms - last_ff;

   always_comb begin
      switched = 1'b0;
      state_in = state_ff;
      last_in  = last_ff;
      if (target != state_ff &&
          elapsed >= {{(ddrc_pkg::TIME_W - ddrc_pkg::MS_W){1'b0}}, min_interval_ms}) begin
         switched = 1'b1;
         state_in = target;
         last_in  = now_ms;
      end
   end

   assign state_next = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 1'b0;
         last_ff  <= '0;
      end else if (enable) begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule
